>>> design/pidm_pkg.sv
`default_nettype none

package pidm_pkg;

  localparam int SUM_W = 48;
  localparam int SUM_SPLIT = 24;
  localparam int GAIN_W = 16;
  localparam int VEL_W = 16;
  localparam int VMAX_W = 15;
  localparam int CNT_W = 16;
  localparam int ACC_W = 66;
  localparam int CFG_IDX_W = 3;
  localparam int TERM_SHIFT = 60;

  localparam logic [GAIN_W-1:0] GAIN_P_RESET = 16'd256;
  localparam logic [GAIN_W-1:0] GAIN_I_RESET = 16'd0;
  localparam logic [GAIN_W-1:0] GAIN_D_RESET = 16'd0;
  localparam logic [VMAX_W-1:0] MAX_VEL_RESET = 15'd400;
  localparam logic [GAIN_W-1:0] SETTLE_TOL_RESET = 16'd5;
  localparam logic [CNT_W-1:0] ITER_LIMIT_RESET = 16'd1000;

  typedef enum logic [1:0] {
    STATUS_IDLE    = 2'd0,
    STATUS_RUNNING = 2'd1,
    STATUS_SETTLED = 2'd2,
    STATUS_TIMEOUT = 2'd3
  } move_status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET     = 3'd0,
    REG_GAIN_P     = 3'd1,
    REG_GAIN_I     = 3'd2,
    REG_GAIN_D     = 3'd3,
    REG_MAX_VEL    = 3'd4,
    REG_SETTLE_TOL = 3'd5,
    REG_ITER_LIMIT = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [GAIN_W-1:0] gain_p;
    logic [GAIN_W-1:0] gain_i;
    logic [GAIN_W-1:0] gain_d;
  } gains_t;

endpackage

`default_nettype wire

>>> design/pidm_if.sv
`default_nettype none

interface pidm_in_if #(parameter int POSITION_WIDTH = 24);
  logic                             valid;
  logic                             ready;
  logic signed [POSITION_WIDTH-1:0] position;
  logic                             start_move;

  modport source(output valid, position, start_move, input ready);
  modport sink(input valid, position, start_move, output ready);
endinterface

interface pidm_out_if;
  logic              valid;
  logic              ready;
  logic signed [15:0] velocity_command;
  logic [1:0]        move_status;

  modport source(output valid, velocity_command, move_status, input ready);
  modport sink(input valid, velocity_command, move_status, output ready);
endinterface

interface pidm_cfg_if #(parameter int DATA_W = 24);
  logic              valid;
  logic              ready;
  logic [2:0]        index;
  logic [DATA_W-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> design/pidm_state.sv
`default_nettype none

module pidm_state #(
  parameter int POSITION_WIDTH = 24
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [POSITION_WIDTH-1:0]      position,
  input  logic                                  start_move,
  input  logic signed [POSITION_WIDTH-1:0]      goal_position,
  input  logic [pidm_pkg::GAIN_W-1:0]           settle_tolerance,
  input  logic [pidm_pkg::CNT_W-1:0]            iteration_limit,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [POSITION_WIDTH:0]        err,
  output logic signed [POSITION_WIDTH+1:0]      der,
  output logic signed [pidm_pkg::SUM_W-1:0]     sum,
  output pidm_pkg::move_status_t                status
);
  import pidm_pkg::*;

  localparam int ERR_W = POSITION_WIDTH + 1;
  localparam int DER_W = POSITION_WIDTH + 2;
  localparam int MAG_W = (ERR_W > GAIN_W) ? ERR_W : GAIN_W;

  logic signed [SUM_W-1:0] error_sum, error_sum_next;
  logic signed [ERR_W-1:0] last_error, last_error_next;
  logic [CNT_W-1:0]        step_count, step_count_next;
  logic                    move_active, move_active_next;

  logic                    take;
  logic                    active_now;
  logic signed [ERR_W-1:0] err_c;
  logic signed [DER_W-1:0] der_c;
  logic signed [SUM_W:0]   sum_wide;
  logic signed [SUM_W-1:0] sum_sat;
  logic [CNT_W-1:0]        cnt_inc;
  logic [ERR_W-1:0]        mag_raw;
  logic [MAG_W-1:0]        mag;
  logic                    settled;
  logic                    timeout;
  move_status_t            status_c;

  assign in_ready = !out_valid || out_ready;
  assign take = in_valid && in_ready;

  always_comb begin
    active_now = start_move || move_active;
    err_c = ERR_W'(goal_position) - ERR_W'(position);
    der_c = DER_W'(err_c) - DER_W'(last_error);
    sum_wide = (SUM_W + 1)'(error_sum) + (SUM_W + 1)'(err_c);
    if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
      sum_sat = sum_wide[SUM_W] ? {1'b1, {(SUM_W - 1){1'b0}}} : {1'b0, {(SUM_W - 1){1'b1}}};
    end else begin
      sum_sat = sum_wide[SUM_W-1:0];
    end
    cnt_inc = (start_move ? '0 : step_count) + CNT_W'(1);
    mag_raw = err_c[ERR_W-1] ? -err_c : err_c;
    mag = MAG_W'(mag_raw);
    settled = mag < MAG_W'(settle_tolerance);
    timeout = cnt_inc >= iteration_limit;

    error_sum_next = error_sum;
    last_error_next = last_error;
    step_count_next = step_count;
    move_active_next = move_active;
    status_c = STATUS_IDLE;
    if (take && active_now) begin
      error_sum_next = sum_sat;
      last_error_next = err_c;
      step_count_next = cnt_inc;
      move_active_next = !(settled || timeout);
      if (settled) begin
        status_c = STATUS_SETTLED;
      end else if (timeout) begin
        status_c = STATUS_TIMEOUT;
      end else begin
        status_c = STATUS_RUNNING;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      error_sum <= '0;
      last_error <= '0;
      step_count <= '0;
      move_active <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      error_sum <= error_sum_next;
      last_error <= last_error_next;
      step_count <= step_count_next;
      move_active <= move_active_next;
      if (in_ready) begin
        out_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      err <= err_c;
      der <= der_c;
      sum <= sum_sat;
      status <= status_c;
    end
  end

endmodule

`default_nettype wire

>>> design/pidm_mult.sv
`default_nettype none

module pidm_mult #(
  parameter int POSITION_WIDTH = 24
) (
  input  logic                                                    clk,
  input  logic                                                    rst,
  input  logic                                                    in_valid,
  output logic                                                    in_ready,
  input  logic signed [POSITION_WIDTH:0]                          err,
  input  logic signed [POSITION_WIDTH+1:0]                        der,
  input  logic signed [pidm_pkg::SUM_W-1:0]                       sum,
  input  pidm_pkg::move_status_t                                  in_status,
  input  pidm_pkg::gains_t                                        gains,
  output logic                                                    out_valid,
  input  logic                                                    out_ready,
  output logic signed [pidm_pkg::GAIN_W+POSITION_WIDTH+1:0]       p_term,
  output logic signed [pidm_pkg::GAIN_W+POSITION_WIDTH+2:0]       d_term,
  output logic signed [pidm_pkg::GAIN_W+pidm_pkg::SUM_W-pidm_pkg::SUM_SPLIT:0] i_hi,
  output logic [pidm_pkg::GAIN_W+pidm_pkg::SUM_SPLIT-1:0]         i_lo,
  output logic signed [pidm_pkg::SUM_W-1:0]                       out_sum,
  output pidm_pkg::move_status_t                                  out_status
);
  import pidm_pkg::*;

  localparam int P_W = GAIN_W + POSITION_WIDTH + 2;
  localparam int D_W = GAIN_W + POSITION_WIDTH + 3;
  localparam int HI_W = GAIN_W + SUM_W - SUM_SPLIT + 1;
  localparam int LO_W = GAIN_W + SUM_SPLIT;

  logic              take;
  logic signed [P_W-1:0]  p_c;
  logic signed [D_W-1:0]  d_c;
  logic signed [HI_W-1:0] hi_c;
  logic [LO_W-1:0]        lo_c;

  assign in_ready = !out_valid || out_ready;
  assign take = in_valid && in_ready;

  always_comb begin
    p_c = $signed({1'b0, gains.gain_p}) * err;
    d_c = $signed({1'b0, gains.gain_d}) * der;
    hi_c = $signed({1'b0, gains.gain_i}) * $signed(sum[SUM_W-1:SUM_SPLIT]);
    lo_c = gains.gain_i * sum[SUM_SPLIT-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      p_term <= p_c;
      d_term <= d_c;
      i_hi <= hi_c;
      i_lo <= lo_c;
      out_sum <= sum;
      out_status <= in_status;
    end
  end

endmodule

`default_nettype wire

>>> design/pidm_accum.sv
`default_nettype none

module pidm_accum #(
  parameter int POSITION_WIDTH = 24,
  parameter int GAIN_FRACTION_BITS = 8
) (
  input  logic                                                    clk,
  input  logic                                                    rst,
  input  logic                                                    in_valid,
  output logic                                                    in_ready,
  input  logic signed [pidm_pkg::GAIN_W+POSITION_WIDTH+1:0]       p_term,
  input  logic signed [pidm_pkg::GAIN_W+POSITION_WIDTH+2:0]       d_term,
  input  logic signed [pidm_pkg::GAIN_W+pidm_pkg::SUM_W-pidm_pkg::SUM_SPLIT:0] i_hi,
  input  logic [pidm_pkg::GAIN_W+pidm_pkg::SUM_SPLIT-1:0]         i_lo,
  input  logic signed [pidm_pkg::SUM_W-1:0]                       sum,
  input  pidm_pkg::move_status_t                                  in_status,
  output logic                                                    out_valid,
  input  logic                                                    out_ready,
  output logic signed [pidm_pkg::ACC_W-1:0]                       acc,
  output pidm_pkg::move_status_t                                  out_status
);
  import pidm_pkg::*;

  localparam logic signed [ACC_W-1:0] TERM_LIM = ACC_W'(1) <<< TERM_SHIFT;

  logic                    mid_valid;
  logic                    mid_ready;
  logic                    take_in;
  logic                    take_mid;
  logic signed [ACC_W-1:0] pd_sum;
  logic signed [ACC_W-1:0] i_sum;
  logic                    i_over;
  logic                    i_under;
  move_status_t            mid_status;
  logic signed [ACC_W-1:0] pd_c;
  logic signed [ACC_W-1:0] i_c;
  logic signed [ACC_W-1:0] i_scaled_c;
  logic                    i_over_c;
  logic                    i_under_c;
  logic signed [ACC_W-1:0] i_sel;
  logic signed [ACC_W-1:0] acc_c;

  assign mid_ready = !out_valid || out_ready;
  assign in_ready = !mid_valid || mid_ready;
  assign take_in = in_valid && in_ready;
  assign take_mid = mid_valid && mid_ready;

  // The integral term saturates once the sum times (gain + 1) passes the term limit.
  always_comb begin
    pd_c = ACC_W'(p_term) + ACC_W'(d_term);
    i_c = (ACC_W'(i_hi) <<< SUM_SPLIT) + $signed(ACC_W'(i_lo));
    i_scaled_c = i_c + ACC_W'(sum);
    i_over_c = i_scaled_c > TERM_LIM;
    i_under_c = i_scaled_c < -TERM_LIM;
    if (i_over) begin
      i_sel = TERM_LIM;
    end else if (i_under) begin
      i_sel = -TERM_LIM;
    end else begin
      i_sel = i_sum;
    end
    acc_c = (pd_sum + i_sel) >>> GAIN_FRACTION_BITS;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        mid_valid <= in_valid;
      end
      if (mid_ready) begin
        out_valid <= mid_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) begin
      pd_sum <= pd_c;
      i_sum <= i_c;
      i_over <= i_over_c;
      i_under <= i_under_c;
      mid_status <= in_status;
    end
    if (take_mid) begin
      acc <= acc_c;
      out_status <= mid_status;
    end
  end

endmodule

`default_nettype wire

>>> design/pidm_clamp.sv
`default_nettype none

module pidm_clamp (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [pidm_pkg::ACC_W-1:0]  acc,
  input  pidm_pkg::move_status_t             in_status,
  input  logic [pidm_pkg::VMAX_W-1:0]        max_velocity,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [pidm_pkg::VEL_W-1:0]  velocity_command,
  output pidm_pkg::move_status_t             move_status
);
  import pidm_pkg::*;

  logic                    take;
  logic signed [ACC_W-1:0] lim;
  logic signed [ACC_W-1:0] neg_lim;
  logic signed [VEL_W-1:0] vel_c;

  assign in_ready = !out_valid || out_ready;
  assign take = in_valid && in_ready;

  always_comb begin
    lim = $signed(ACC_W'(max_velocity));
    neg_lim = -lim;
    if (acc > lim) begin
      vel_c = lim[VEL_W-1:0];
    end else if (acc < neg_lim) begin
      vel_c = neg_lim[VEL_W-1:0];
    end else begin
      vel_c = acc[VEL_W-1:0];
    end
    // Only a running or timed-out step drives the motor.
    if (in_status != STATUS_RUNNING && in_status != STATUS_TIMEOUT) begin
      vel_c = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      velocity_command <= vel_c;
      move_status <= in_status;
    end
  end

endmodule

`default_nettype wire

>>> design/pid_position_move_controller.sv
// Channel  Role   Payload                                  Accepted when
// sample   sink   position, start_move                     valid && ready
// result   source velocity_command, move_status            valid && ready
// cfg      sink   index, data (register write)             valid && ready
//
// One item is accepted per clock while the result is not stalled; items overlap.
// The error sum, last error and step count update as the item leaves the input
// register, so consecutive items follow each other with no gap.
// Synchronous reset clears the move state and valids and loads cfg reset values.
// A stalled result only backs up the pipeline stage by stage; cfg is always ready.
`default_nettype none

module pid_position_move_controller #(
  parameter int POSITION_WIDTH = 24,
  parameter int GAIN_FRACTION_BITS = 8
) (
  input  logic       clk,
  input  logic       rst,
  pidm_in_if.sink    sample,
  pidm_out_if.source result,
  pidm_cfg_if.sink   cfg
);
  import pidm_pkg::*;

  localparam int ERR_W = POSITION_WIDTH + 1;
  localparam int DER_W = POSITION_WIDTH + 2;
  localparam int P_W = GAIN_W + POSITION_WIDTH + 2;
  localparam int D_W = GAIN_W + POSITION_WIDTH + 3;
  localparam int HI_W = GAIN_W + SUM_W - SUM_SPLIT + 1;
  localparam int LO_W = GAIN_W + SUM_SPLIT;

  logic signed [POSITION_WIDTH-1:0] goal_position;
  gains_t                           gains;
  logic [VMAX_W-1:0]                max_velocity;
  logic [GAIN_W-1:0]                settle_tolerance;
  logic [CNT_W-1:0]                 iteration_limit;

  logic                             in_valid;
  logic                             st_ready;
  logic signed [POSITION_WIDTH-1:0] in_position;
  logic                             in_start;

  logic                    st_valid;
  logic                    mu_ready;
  logic signed [ERR_W-1:0] st_err;
  logic signed [DER_W-1:0] st_der;
  logic signed [SUM_W-1:0] st_sum;
  move_status_t            st_status;

  logic                    mu_valid;
  logic                    ac_ready;
  logic signed [P_W-1:0]   mu_p;
  logic signed [D_W-1:0]   mu_d;
  logic signed [HI_W-1:0]  mu_hi;
  logic [LO_W-1:0]         mu_lo;
  logic signed [SUM_W-1:0] mu_sum;
  move_status_t            mu_status;

  logic                    ac_valid;
  logic                    cl_ready;
  logic signed [ACC_W-1:0] ac_acc;
  move_status_t            ac_status;

  move_status_t            out_status;

  assign cfg.ready = 1'b1;
  assign sample.ready = !in_valid || st_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      goal_position <= '0;
      gains.gain_p <= GAIN_P_RESET;
      gains.gain_i <= GAIN_I_RESET;
      gains.gain_d <= GAIN_D_RESET;
      max_velocity <= MAX_VEL_RESET;
      settle_tolerance <= SETTLE_TOL_RESET;
      iteration_limit <= ITER_LIMIT_RESET;
    end else if (cfg.valid) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_TARGET:     goal_position <= $signed(cfg.data[POSITION_WIDTH-1:0]);
        REG_GAIN_P:     gains.gain_p <= cfg.data[GAIN_W-1:0];
        REG_GAIN_I:     gains.gain_i <= cfg.data[GAIN_W-1:0];
        REG_GAIN_D:     gains.gain_d <= cfg.data[GAIN_W-1:0];
        REG_MAX_VEL:    max_velocity <= cfg.data[VMAX_W-1:0];
        REG_SETTLE_TOL: settle_tolerance <= cfg.data[GAIN_W-1:0];
        REG_ITER_LIMIT: iteration_limit <= cfg.data[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (sample.ready) begin
      in_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      in_position <= sample.position;
      in_start <= sample.start_move;
    end
  end

  pidm_state #(
    .POSITION_WIDTH(POSITION_WIDTH)
  ) u_state (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (st_ready),
    .position         (in_position),
    .start_move       (in_start),
    .goal_position    (goal_position),
    .settle_tolerance (settle_tolerance),
    .iteration_limit  (iteration_limit),
    .out_valid        (st_valid),
    .out_ready        (mu_ready),
    .err              (st_err),
    .der              (st_der),
    .sum              (st_sum),
    .status           (st_status)
  );

  pidm_mult #(
    .POSITION_WIDTH(POSITION_WIDTH)
  ) u_mult (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (st_valid),
    .in_ready   (mu_ready),
    .err        (st_err),
    .der        (st_der),
    .sum        (st_sum),
    .in_status  (st_status),
    .gains      (gains),
    .out_valid  (mu_valid),
    .out_ready  (ac_ready),
    .p_term     (mu_p),
    .d_term     (mu_d),
    .i_hi       (mu_hi),
    .i_lo       (mu_lo),
    .out_sum    (mu_sum),
    .out_status (mu_status)
  );

  pidm_accum #(
    .POSITION_WIDTH     (POSITION_WIDTH),
    .GAIN_FRACTION_BITS (GAIN_FRACTION_BITS)
  ) u_accum (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (mu_valid),
    .in_ready   (ac_ready),
    .p_term     (mu_p),
    .d_term     (mu_d),
    .i_hi       (mu_hi),
    .i_lo       (mu_lo),
    .sum        (mu_sum),
    .in_status  (mu_status),
    .out_valid  (ac_valid),
    .out_ready  (cl_ready),
    .acc        (ac_acc),
    .out_status (ac_status)
  );

  pidm_clamp u_clamp (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (ac_valid),
    .in_ready         (cl_ready),
    .acc              (ac_acc),
    .in_status        (ac_status),
    .max_velocity     (max_velocity),
    .out_valid        (result.valid),
    .out_ready        (result.ready),
    .velocity_command (result.velocity_command),
    .move_status      (out_status)
  );

  assign result.move_status = out_status;

endmodule

`default_nettype wire

>>> design/pidm_checker.sv
`default_nettype none

module pidm_checker (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input logic signed [15:0] velocity_command,
  input logic [1:0]        move_status
);
  import pidm_pkg::*;

  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && move_status == STATUS_IDLE) |-> velocity_command == 16'sd0)
    else $error("idle result carries a nonzero velocity");

  a_settled_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && move_status == STATUS_SETTLED) |-> velocity_command == 16'sd0)
    else $error("settled result carries a nonzero velocity");

  a_clamp_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> velocity_command != -16'sd32768)
    else $error("velocity outside the clamp range");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(velocity_command) && $stable(move_status)))
    else $error("stalled result changed");

endmodule

bind pid_position_move_controller pidm_checker u_pidm_checker (
  .clk              (clk),
  .rst              (rst),
  .out_valid        (result.valid),
  .out_ready        (result.ready),
  .velocity_command (result.velocity_command),
  .move_status      (result.move_status)
);

`default_nettype wire

>>> test/tb.sv
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pidm_pkg::*;

  localparam int POS_W = 24;
  localparam int FRAC = 8;
  localparam longint POS_HI = 64'sd8388607;
  localparam longint POS_LO = -64'sd8388608;
  localparam longint SUM_HI = (longint'(1) <<< 47) - 1;
  localparam longint SUM_LO = -SUM_HI - 1;
  localparam longint TERM_LIM = longint'(1) <<< 60;
  localparam int PHASES = 9;
  localparam int PHASE_ITEMS = 90;
  localparam int DRAIN = 8;
  localparam int HOLD_AT = 300;
  localparam int HOLD_CYCLES = 200;

  typedef enum logic {ROW_SAMPLE, ROW_REG} row_kind_t;

  typedef struct packed {
    logic signed [VEL_W-1:0] vel;
    move_status_t            status;
  } cmd_t;

  typedef struct packed {
    row_kind_t               kind;
    cfg_reg_t                idx;
    logic signed [POS_W-1:0] value;
    logic                    start;
    logic                    typed;
    cmd_t                    cmd;
  } plan_row_t;

  logic clk;
  logic rst;

  pidm_in_if #(.POSITION_WIDTH(POS_W)) smp ();
  pidm_out_if res ();
  pidm_cfg_if #(.DATA_W(POS_W)) cfg_ch ();

  pid_position_move_controller DUT (
    .clk(clk),
    .rst(rst),
    .sample(smp),
    .result(res),
    .cfg(cfg_ch)
  );

  logic signed [POS_W-1:0] goal = '0;
  logic [GAIN_W-1:0] kp = GAIN_P_RESET;
  logic [GAIN_W-1:0] ki = GAIN_I_RESET;
  logic [GAIN_W-1:0] kd = GAIN_D_RESET;
  logic [VMAX_W-1:0] vel_limit = MAX_VEL_RESET;
  logic [GAIN_W-1:0] tol = SETTLE_TOL_RESET;
  logic [CNT_W-1:0] step_limit = ITER_LIMIT_RESET;

  logic signed [SUM_W-1:0] integ = '0;
  logic signed [POS_W:0] prev_err = '0;
  logic [CNT_W-1:0] steps = '0;
  logic running = 1'b0;

  cmd_t expected_cmds[$];
  plan_row_t plan[$];
  int fail_count = 0;
  int results_seen = 0;
  int live_items = 0;
  int src_idle_pct = 0;
  int sink_idle_pct = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("CHECK FAILED");
    $finish;
  end

  task automatic note_mismatch(input string msg);
    fail_count++;
    if (fail_count <= 50) $display("%0t mismatch: %s", $time, msg);
  endtask

  function automatic longint gain_term(input longint g, input longint v);
    longint bound;
    bound = TERM_LIM / (g + 1);
    if (v > bound) return TERM_LIM;
    if (v < -bound) return -TERM_LIM;
    if (g * v > TERM_LIM) return TERM_LIM;
    if (g * v < -TERM_LIM) return -TERM_LIM;
    return g * v;
  endfunction

  function automatic cmd_t pid_step(input logic signed [POS_W-1:0] pos, input logic start);
    cmd_t r;
    longint e, der, s, acc, lim, v, mag;
    r.vel = '0;
    r.status = STATUS_IDLE;
    if (start) begin
      running = 1'b1;
      steps = '0;
    end
    if (running) begin
      e = longint'(goal) - longint'(pos);
      der = e - longint'(prev_err);
      s = longint'(integ) + e;
      if (s > SUM_HI) s = SUM_HI;
      else if (s < SUM_LO) s = SUM_LO;
      integ = s[SUM_W-1:0];
      acc = gain_term(longint'(kp), e) + gain_term(longint'(ki), s)
          + gain_term(longint'(kd), der);
      lim = longint'(vel_limit);
      v = acc >>> FRAC;
      if (v > lim) v = lim;
      else if (v < -lim) v = -lim;
      prev_err = e[POS_W:0];
      steps = steps + 1'b1;
      mag = (e < 0) ? -e : e;
      if (mag < longint'(tol)) begin
        r.status = STATUS_SETTLED;
        running = 1'b0;
      end else if (steps >= step_limit) begin
        r.vel = v[VEL_W-1:0];
        r.status = STATUS_TIMEOUT;
        running = 1'b0;
      end else begin
        r.vel = v[VEL_W-1:0];
        r.status = STATUS_RUNNING;
      end
    end
    return r;
  endfunction

  function automatic void set_reg(input cfg_reg_t idx, input logic [POS_W-1:0] val);
    case (idx)
      REG_TARGET: goal = val;
      REG_GAIN_P: kp = val[GAIN_W-1:0];
      REG_GAIN_I: ki = val[GAIN_W-1:0];
      REG_GAIN_D: kd = val[GAIN_W-1:0];
      REG_MAX_VEL: vel_limit = val[VMAX_W-1:0];
      REG_SETTLE_TOL: tol = val[GAIN_W-1:0];
      REG_ITER_LIMIT: step_limit = val[CNT_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic logic signed [POS_W-1:0] near_target(input int unsigned span);
    longint p;
    p = longint'(goal) + longint'($urandom_range(0, 2 * span)) - longint'(span);
    if (p > POS_HI) p = POS_HI;
    if (p < POS_LO) p = POS_LO;
    return p[POS_W-1:0];
  endfunction

  function automatic logic [POS_W-1:0] pick_gain();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return POS_W'($urandom_range(0, 512));
      2: return POS_W'($urandom_range(0, 4096));
      default: return POS_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic plan_row_t sample_row(input logic signed [POS_W-1:0] pos,
                                           input logic start);
    plan_row_t r;
    r = '0;
    r.kind = ROW_SAMPLE;
    r.value = pos;
    r.start = start;
    return r;
  endfunction

  function automatic plan_row_t typed_row(input logic signed [POS_W-1:0] pos,
                                          input logic start,
                                          input logic signed [VEL_W-1:0] vel,
                                          input move_status_t status);
    plan_row_t r;
    r = sample_row(pos, start);
    r.typed = 1'b1;
    r.cmd.vel = vel;
    r.cmd.status = status;
    return r;
  endfunction

  function automatic plan_row_t reg_row(input cfg_reg_t idx, input logic [POS_W-1:0] val);
    plan_row_t r;
    r = '0;
    r.kind = ROW_REG;
    r.idx = idx;
    r.value = val;
    return r;
  endfunction

  task automatic send_sample(input logic signed [POS_W-1:0] pos, input logic start,
                             input logic typed, input cmd_t typed_cmd);
    cmd_t predicted;
    while ($urandom_range(1, 100) <= src_idle_pct) begin
      smp.valid <= 1'b0;
      @(posedge clk);
    end
    smp.valid <= 1'b1;
    smp.position <= pos;
    smp.start_move <= start;
    @(posedge clk);
    while (!smp.ready) @(posedge clk);
    predicted = pid_step(pos, start);
    if (predicted.status != STATUS_IDLE) live_items++;
    expected_cmds.push_back(typed ? typed_cmd : predicted);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [POS_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    set_reg(idx, val);
  endtask

  task automatic drain_pipeline();
    smp.valid <= 1'b0;
    while (expected_cmds.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic check_result();
    cmd_t want;
    if (expected_cmds.size() == 0) begin
      note_mismatch($sformatf("unexpected result: velocity %0d status %0d",
                              res.velocity_command, res.move_status));
      return;
    end
    want = expected_cmds.pop_front();
    if (res.velocity_command !== want.vel)
      note_mismatch($sformatf("velocity %0d, expected %0d", res.velocity_command, want.vel));
    if (res.move_status !== want.status)
      note_mismatch($sformatf("status %0d, expected %0d", res.move_status, want.status));
  endtask

  initial begin : result_sink
    int hold_left;
    logic hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    res.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res.valid && res.ready) begin
        check_result();
        results_seen++;
      end
      if (!hold_done && results_seen >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res.ready <= 1'b0;
      end else begin
        res.ready <= ($urandom_range(1, 100) > sink_idle_pct);
      end
    end
  end

  initial begin : stimulus
    plan_row_t row;
    logic [POS_W-1:0] vals[7];
    int unsigned span;
    int n;
    int phase_end;
    rst <= 1'b1;
    smp.valid <= 1'b0;
    smp.position <= '0;
    smp.start_move <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= REG_TARGET;
    cfg_ch.data <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    src_idle_pct = 10;
    sink_idle_pct = 85;
    @(posedge clk);

    plan.push_back(typed_row(24'sd123, 1'b0, 16'sd0, STATUS_IDLE));
    plan.push_back(typed_row(24'sd0, 1'b1, 16'sd0, STATUS_SETTLED));
    plan.push_back(typed_row(-24'sd8388608, 1'b1, 16'sd400, STATUS_RUNNING));
    plan.push_back(typed_row(24'sd8388607, 1'b0, -16'sd400, STATUS_RUNNING));
    plan.push_back(typed_row(24'sd100, 1'b0, -16'sd100, STATUS_RUNNING));
    plan.push_back(typed_row(-24'sd3, 1'b0, 16'sd0, STATUS_SETTLED));
    plan.push_back(typed_row(24'sd8388607, 1'b0, 16'sd0, STATUS_IDLE));
    plan.push_back(typed_row(24'sd200, 1'b1, -16'sd200, STATUS_RUNNING));
    plan.push_back(typed_row(-24'sd50, 1'b1, 16'sd50, STATUS_RUNNING));
    plan.push_back(typed_row(24'sd4, 1'b0, 16'sd0, STATUS_SETTLED));
    plan.push_back(reg_row(REG_ITER_LIMIT, 24'd0));
    plan.push_back(typed_row(24'sd1000, 1'b1, -16'sd400, STATUS_TIMEOUT));
    plan.push_back(typed_row(24'sd1000, 1'b0, 16'sd0, STATUS_IDLE));
    plan.push_back(reg_row(REG_ITER_LIMIT, 24'd3));
    plan.push_back(typed_row(24'sd10, 1'b1, -16'sd10, STATUS_RUNNING));
    plan.push_back(typed_row(24'sd10, 1'b1, -16'sd10, STATUS_RUNNING));
    plan.push_back(typed_row(24'sd10, 1'b0, -16'sd10, STATUS_RUNNING));
    plan.push_back(typed_row(24'sd10, 1'b0, -16'sd10, STATUS_TIMEOUT));
    plan.push_back(reg_row(REG_TARGET, 24'h800000));
    plan.push_back(reg_row(REG_GAIN_P, 24'd65535));
    plan.push_back(reg_row(REG_GAIN_I, 24'd65535));
    plan.push_back(reg_row(REG_GAIN_D, 24'd65535));
    plan.push_back(reg_row(REG_MAX_VEL, 24'd32767));
    plan.push_back(reg_row(REG_SETTLE_TOL, 24'd0));
    plan.push_back(reg_row(REG_ITER_LIMIT, 24'd65535));
    plan.push_back(sample_row(24'sd8388607, 1'b1));
    plan.push_back(sample_row(-24'sd8388608, 1'b0));
    plan.push_back(sample_row(24'sd0, 1'b0));
    plan.push_back(sample_row(24'sd8388607, 1'b0));
    plan.push_back(reg_row(REG_TARGET, 24'h7FFFFF));
    plan.push_back(reg_row(REG_GAIN_P, 24'd0));
    plan.push_back(reg_row(REG_GAIN_I, 24'd0));
    plan.push_back(reg_row(REG_GAIN_D, 24'd0));
    plan.push_back(reg_row(REG_MAX_VEL, 24'd0));
    plan.push_back(reg_row(REG_SETTLE_TOL, 24'd65535));
    plan.push_back(sample_row(-24'sd8388608, 1'b1));
    plan.push_back(sample_row(24'sd8388607, 1'b0));

    foreach (plan[i]) begin
      row = plan[i];
      if (row.kind == ROW_REG) begin
        drain_pipeline();
        write_reg(row.idx, row.value);
        cfg_ch.valid <= 1'b0;
      end else begin
        send_sample(row.value, row.start, row.typed, row.cmd);
      end
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase < 3) begin
        src_idle_pct = 10;
        sink_idle_pct = 85;
      end else if (phase < 6) begin
        src_idle_pct = 85;
        sink_idle_pct = 10;
      end else begin
        src_idle_pct = 0;
        sink_idle_pct = 0;
      end
      if (phase == 0) begin
        vals = '{24'h7FFFFF, 24'd65535, 24'd65535, 24'd65535, 24'd32767, 24'd65535,
                 24'd65535};
      end else if (phase == 1) begin
        vals = '{24'h800000, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0};
      end else begin
        vals[REG_TARGET] = POS_W'($urandom());
        if ($urandom_range(0, 7) == 0)
          vals[REG_TARGET] = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
        vals[REG_GAIN_P] = pick_gain();
        vals[REG_GAIN_I] = pick_gain();
        vals[REG_GAIN_D] = pick_gain();
        vals[REG_MAX_VEL] = POS_W'($urandom_range(0, 32767));
        vals[REG_SETTLE_TOL] = ($urandom_range(0, 7) == 0) ? 24'd65535
                                                            : POS_W'($urandom_range(0, 300));
        case ($urandom_range(0, 7))
          0: vals[REG_ITER_LIMIT] = 24'd0;
          1: vals[REG_ITER_LIMIT] = 24'd65535;
          default: vals[REG_ITER_LIMIT] = POS_W'($urandom_range(1, 16));
        endcase
      end
      drain_pipeline();
      write_reg(REG_TARGET, vals[REG_TARGET]);
      write_reg(REG_GAIN_P, vals[REG_GAIN_P]);
      write_reg(REG_GAIN_I, vals[REG_GAIN_I]);
      write_reg(REG_GAIN_D, vals[REG_GAIN_D]);
      write_reg(REG_MAX_VEL, vals[REG_MAX_VEL]);
      write_reg(REG_SETTLE_TOL, vals[REG_SETTLE_TOL]);
      write_reg(REG_ITER_LIMIT, vals[REG_ITER_LIMIT]);
      cfg_ch.valid <= 1'b0;

      // Most moves close in on the target so that both settling and time-outs occur.
      phase_end = live_items + PHASE_ITEMS;
      while (live_items < phase_end) begin
        if ($urandom_range(1, 100) <= 80) begin
          span = 1 << $urandom_range(0, 22);
          send_sample(near_target(span), 1'b1, 1'b0, '0);
          n = $urandom_range(1, 12);
          while (running && n > 0) begin
            span = (span > 3) ? span - (span >> 2) : span;
            send_sample(near_target(span), ($urandom_range(1, 100) <= 5), 1'b0, '0);
            n--;
          end
        end else begin
          send_sample(POS_W'($urandom()), 1'($urandom_range(0, 1)), 1'b0, '0);
        end
      end
    end

    drain_pipeline();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
